[hdl/sohist_pkg.sv]
// Shared constants, tangent table and store access type for the segment orientation histogram.
`timescale 1ns / 1ps
package sohist_pkg;

   localparam int MAX_CELLS   = 512;
   localparam int ANGLE_BINS  = 36;
   localparam int COUNT_BITS  = 16;
   localparam int STORE_DEPTH = MAX_CELLS * ANGLE_BINS;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int GRID_LIMIT  = 64;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic [39:0] TAN_SCALE = 40'd1000000000000;

   localparam logic [42:0] TANK [8] = '{
      43'd176326980708,  43'd363970234266,  43'd577350269190,  43'd839099631177,
      43'd1191753592594, 43'd1732050807569, 43'd2747477419455, 43'd5671281819618
   };

   typedef struct packed {
      logic                  wr_en;
      logic [ADDR_BITS-1:0]  wr_addr;
      logic [COUNT_BITS-1:0] wr_data;
      logic [ADDR_BITS-1:0]  rd_addr;
   } store_req_type;

endpackage

[hdl/sohist_divider.sv]
// Restoring divider that yields one quotient bit of a pixel coordinate per cycle.
`timescale 1ns / 1ps
module sohist_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [11:0] dividend,
   input  logic [7:0]  divisor,
   output logic [11:0] quotient,
   output logic        done
);
   logic [11:0] quot_ff, quot_in;
   logic [7:0]  rem_ff, rem_in;
   logic [7:0]  div_ff;
   logic [3:0]  cnt_ff;
   logic        busy_ff, done_ff;
   logic [8:0]  trial;
   logic        ge;

   always_comb begin
      trial   = {rem_ff, quot_ff[11]};
      ge      = trial >= {1'b0, div_ff};
      rem_in  = ge ? 8'(trial - {1'b0, div_ff}) : trial[7:0];
      quot_in = {quot_ff[10:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         quot_ff <= dividend;
         rem_ff  <= '0;
         div_ff  <= divisor;
      end else if (busy_ff) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
         cnt_ff  <= cnt_ff + 4'd1;
         if (cnt_ff == 4'd11) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign quotient = quot_ff;
   assign done     = done_ff;
endmodule

[hdl/sohist_dirbin.sv]
// Direction bin finder that compares the slope against one tangent threshold per cycle.
`timescale 1ns / 1ps
module sohist_dirbin (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [11:0] abs_dx,
   input  logic [11:0] abs_dy,
   input  logic        dx_neg,
   input  logic        dy_neg,
   output logic [5:0]  bin,
   output logic        done
);
   import sohist_pkg::*;

   logic [11:0] ax_ff, ay_ff;
   logic        dxn_ff, dyn_ff;
   logic [54:0] prod_ff;
   logic [51:0] ay_sc_ff;
   logic [3:0]  cnt_ff, s_ff;
   logic        busy_ff, done_ff;
   logic [5:0]  bin_ff, bin_in;
   logic [3:0]  s_eff, c_val;
   logic [5:0]  b_tmp;

   always_comb begin
      s_eff = (ax_ff == '0) ? 4'd9 : s_ff;
      c_val = s_eff + ((ax_ff == '0 || ay_ff == '0) ? 4'd0 : 4'd1);
      b_tmp = 6'd36 - {2'b0, c_val};
      if (ax_ff == '0 && ay_ff == '0)
         bin_in = 6'd18;
      else if (!dyn_ff && !dxn_ff && ax_ff != '0)
         bin_in = 6'd18 + {2'b0, s_eff};
      else if (!dyn_ff)
         bin_in = (b_tmp > 6'd35) ? 6'd35 : b_tmp;
      else if (dxn_ff)
         bin_in = {2'b0, s_eff};
      else
         bin_in = 6'd18 - {2'b0, c_val};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         s_ff    <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         s_ff    <= '0;
         ax_ff   <= abs_dx;
         ay_ff   <= abs_dy;
         dxn_ff  <= dx_neg;
         dyn_ff  <= dy_neg;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 4'd1;
         if (cnt_ff == 4'd0)
            ay_sc_ff <= 52'(ay_ff * TAN_SCALE);
         if (cnt_ff < 4'd8)
            prod_ff <= 55'(ax_ff * TANK[cnt_ff[2:0]]);
         if (cnt_ff != 4'd0 && cnt_ff < 4'd9 && {3'b0, ay_sc_ff} >= prod_ff)
            s_ff <= s_ff + 4'd1;
         if (cnt_ff == 4'd9) begin
            bin_ff  <= bin_in;
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign bin  = bin_ff;
   assign done = done_ff;
endmodule

[hdl/sohist_store.sv]
// Count store with one write port and one registered read port.
`timescale 1ns / 1ps
module sohist_store (
   input  logic                               clock,
   input  sohist_pkg::store_req_type          req,
   output logic [sohist_pkg::COUNT_BITS-1:0]  rd_data
);
   import sohist_pkg::*;

   logic [COUNT_BITS-1:0] mem [STORE_DEPTH];
   logic [COUNT_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en)
         mem[req.wr_addr] <= req.wr_data;
      rd_data_ff <= mem[req.rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[hdl/segment_orientation_cell_histogram.sv]
// Top level of the segment orientation histogram with its control sequencer.
// The request channel takes one transaction at a time. A segment transaction (mode 0)
// takes its lower endpoint, divides both coordinates by the cell size one quotient
// bit per cycle, finds the ten-degree direction bin and increments the saturating
// count in the store; it returns nothing and occupies the block until the twelve-step
// divider and the read-modify-write of the store are through.
// A finish transaction (mode 1) reads the bottom grid row from the store at one count
// per cycle, then offers two response transactions: the nearest candidate right of
// centre, then the nearest left of centre with last set. The responses hold while
// the receiver stalls. After the second response is taken all 18432 entries of the
// store are cleared, one entry per cycle, and no request is taken while this runs.
// The same clearing pass runs after reset. Configuration writes are taken in any
// cycle and are meant for idle periods.
`timescale 1ns / 1ps
module segment_orientation_cell_histogram (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [11:0] req_x_a,
   input  logic [11:0] req_y_a,
   input  logic [11:0] req_x_b,
   input  logic [11:0] req_y_b,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_lane_side,
   output logic        rsp_found,
   output logic [5:0]  rsp_lane_column,
   output logic [5:0]  rsp_angle_bin,
   output logic        rsp_last,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import sohist_pkg::*;

   localparam logic [1:0] CSR_CELL_SIZE = 2'd0;
   localparam logic [1:0] CSR_COL_COUNT = 2'd1;
   localparam logic [1:0] CSR_ROW_COUNT = 2'd2;
   localparam logic [1:0] CSR_MIN_COUNT = 2'd3;

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_CALC  = 4'd2;
   localparam logic [3:0] ST_CELL  = 4'd3;
   localparam logic [3:0] ST_INDEX = 4'd4;
   localparam logic [3:0] ST_READ  = 4'd5;
   localparam logic [3:0] ST_WRITE = 4'd6;
   localparam logic [3:0] ST_SBASE = 4'd7;
   localparam logic [3:0] ST_SADDR = 4'd8;
   localparam logic [3:0] ST_SRUN  = 4'd9;
   localparam logic [3:0] ST_RSP_R = 4'd10;
   localparam logic [3:0] ST_RSP_L = 4'd11;

   logic [3:0]  state_ff;
   logic [7:0]  cell_size_ff;
   logic [6:0]  col_count_ff, row_count_ff;
   logic [15:0] min_count_ff;

   logic [6:0]  cols, rows, centre;
   logic [7:0]  cs;
   logic        take;
   logic        sel_a;
   logic [11:0] abs_dx, abs_dy;
   logic [11:0] row_q, col_q;
   logic        row_done, col_done, bin_done;
   logic [5:0]  bin;

   logic [11:0]           cell_ff;
   logic [ADDR_BITS-1:0]  idx_ff, clr_addr_ff, scan_addr_ff;
   logic [12:0]           base_ff, scan_cell_ff;
   logic [6:0]            scan_position_ff;
   logic [5:0]            scan_bin_ff, pend_col_ff, pend_bin_ff;
   logic                  pend_valid_ff;
   logic                  rf_ff, lf_ff;
   logic [5:0]            rc_ff, rb_ff, lc_ff, lb_ff;
   logic                  scan_go;
   logic                  hit;

   store_req_type         store_req;
   logic [COUNT_BITS-1:0] rd_data;

   always_comb begin
      cols   = (col_count_ff > 7'(GRID_LIMIT)) ? 7'(GRID_LIMIT) : col_count_ff;
      rows   = (row_count_ff > 7'(GRID_LIMIT)) ? 7'(GRID_LIMIT) : row_count_ff;
      centre = cols - (cols >> 1);
      cs     = (cell_size_ff == '0) ? 8'd1 : cell_size_ff;
      take   = req_valid && req_ready;
      sel_a  = req_y_a > req_y_b;
      abs_dx = (req_x_a >= req_x_b) ? req_x_a - req_x_b : req_x_b - req_x_a;
      abs_dy = (req_y_a >= req_y_b) ? req_y_a - req_y_b : req_y_b - req_y_a;
      scan_go = ({1'b0, scan_position_ff} < {1'b0, cols})
                && (scan_cell_ff < 13'(MAX_CELLS));
      hit    = pend_valid_ff && (rd_data >= min_count_ff);
   end

   sohist_divider u_div_row (
      .clock(clock), .reset(reset), .start(take && !req_mode),
      .dividend(sel_a ? req_y_a : req_y_b), .divisor(cs),
      .quotient(row_q), .done(row_done)
   );

   sohist_divider u_div_col (
      .clock(clock), .reset(reset), .start(take && !req_mode),
      .dividend(sel_a ? req_x_a : req_x_b), .divisor(cs),
      .quotient(col_q), .done(col_done)
   );

   sohist_dirbin u_dirbin (
      .clock(clock), .reset(reset), .start(take && !req_mode),
      .abs_dx(abs_dx), .abs_dy(abs_dy),
      .dx_neg(req_x_a < req_x_b), .dy_neg(req_y_a < req_y_b),
      .bin(bin), .done(bin_done)
   );

   always_comb begin
      store_req.wr_en   = 1'b0;
      store_req.wr_addr = idx_ff;
      store_req.wr_data = (rd_data == COUNT_MAX) ? rd_data : rd_data + 1'b1;
      store_req.rd_addr = (state_ff == ST_SRUN) ? scan_addr_ff : idx_ff;
      if (state_ff == ST_CLEAR) begin
         store_req.wr_en   = 1'b1;
         store_req.wr_addr = clr_addr_ff;
         store_req.wr_data = '0;
      end else if (state_ff == ST_WRITE) begin
         store_req.wr_en = 1'b1;
      end
   end

   sohist_store u_store (
      .clock(clock), .req(store_req), .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff <= 8'd60;
         col_count_ff <= 7'd21;
         row_count_ff <= 7'd16;
         min_count_ff <= 16'd2;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_CELL_SIZE: cell_size_ff <= csr_data[7:0];
            CSR_COL_COUNT: col_count_ff <= csr_data[6:0];
            CSR_ROW_COUNT: row_count_ff <= csr_data[6:0];
            CSR_MIN_COUNT: min_count_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clr_addr_ff      <= '0;
         scan_position_ff <= '0;
         pend_valid_ff    <= 1'b0;
         rf_ff            <= 1'b0;
         lf_ff            <= 1'b0;
      end else begin
         if (hit) begin
            if ({1'b0, pend_col_ff} > centre && !rf_ff) begin
               rf_ff <= 1'b1;
               rc_ff <= pend_col_ff;
               rb_ff <= pend_bin_ff;
            end
            if ({1'b0, pend_col_ff} < centre && (!lf_ff || pend_col_ff > lc_ff)) begin
               lf_ff <= 1'b1;
               lc_ff <= pend_col_ff;
               lb_ff <= pend_bin_ff;
            end
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == ADDR_BITS'(STORE_DEPTH - 1))
                  state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (take) begin
                  rf_ff    <= 1'b0;
                  lf_ff    <= 1'b0;
                  state_ff <= req_mode ? ST_SBASE : ST_CALC;
               end
            end
            ST_CALC: begin
               if (row_done && col_done && bin_done)
                  state_ff <= ST_CELL;
            end
            ST_CELL: begin
               cell_ff <= 12'(13'(row_q[5:0] * cols) + {7'b0, col_q[5:0]});
               if (row_q < {5'b0, rows} && col_q < {5'b0, cols})
                  state_ff <= ST_INDEX;
               else
                  state_ff <= ST_IDLE;
            end
            ST_INDEX: begin
               idx_ff <= ADDR_BITS'(cell_ff[8:0] * 6'(ANGLE_BINS)) + ADDR_BITS'(bin);
               if (cell_ff < 12'(MAX_CELLS))
                  state_ff <= ST_READ;
               else
                  state_ff <= ST_IDLE;
            end
            ST_READ:  state_ff <= ST_WRITE;
            ST_WRITE: state_ff <= ST_IDLE;
            ST_SBASE: begin
               base_ff <= 13'((rows - 7'd1) * cols);
               state_ff <= (rows == '0) ? ST_RSP_R : ST_SADDR;
            end
            ST_SADDR: begin
               scan_cell_ff     <= base_ff;
               scan_addr_ff     <= ADDR_BITS'(base_ff[8:0] * 6'(ANGLE_BINS));
               scan_position_ff <= '0;
               scan_bin_ff      <= '0;
               state_ff         <= ST_SRUN;
            end
            ST_SRUN: begin
               if (scan_go) begin
                  pend_valid_ff <= 1'b1;
                  pend_col_ff   <= scan_position_ff[5:0];
                  pend_bin_ff   <= scan_bin_ff;
                  scan_addr_ff  <= scan_addr_ff + 1'b1;
                  if (scan_bin_ff == 6'(ANGLE_BINS - 1)) begin
                     scan_bin_ff      <= '0;
                     scan_position_ff <= scan_position_ff + 7'd1;
                     scan_cell_ff     <= scan_cell_ff + 13'd1;
                  end else begin
                     scan_bin_ff <= scan_bin_ff + 6'd1;
                  end
               end else begin
                  pend_valid_ff    <= 1'b0;
                  scan_position_ff <= '0;
                  state_ff         <= ST_RSP_R;
               end
            end
            ST_RSP_R: begin
               if (rsp_ready)
                  state_ff <= ST_RSP_L;
            end
            ST_RSP_L: begin
               if (rsp_ready) begin
                  clr_addr_ff <= '0;
                  state_ff    <= ST_CLEAR;
               end
            end
            default: state_ff <= ST_CLEAR;
         endcase
      end
   end

   always_comb begin
      req_ready       = state_ff == ST_IDLE;
      rsp_valid       = (state_ff == ST_RSP_R) || (state_ff == ST_RSP_L);
      rsp_last        = state_ff == ST_RSP_L;
      rsp_lane_side   = rsp_last;
      rsp_found       = rsp_last ? lf_ff : rf_ff;
      rsp_lane_column = '0;
      rsp_angle_bin   = '0;
      if (rsp_found) begin
         rsp_lane_column = rsp_last ? lc_ff : rc_ff;
         rsp_angle_bin   = rsp_last ? lb_ff : rb_ff;
      end
   end
endmodule
